>>> sv/adc_calibrate_and_average_core_macros.svh
// Assertion macros for the ADC calibrate and average core.
`ifndef ADC_CALIBRATE_AND_AVERAGE_CORE_MACROS_SVH
`define ADC_CALIBRATE_AND_AVERAGE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ACA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ACA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ACA_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ACA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/aca_pkg.sv
package aca_pkg;

  localparam int unsigned MaxSamples = 16384;
  localparam int unsigned SeenW      = $clog2(MaxSamples + 1);
  localparam int unsigned DvsrW      = SeenW + 1;
  localparam int unsigned CodeW      = 14;
  localparam int unsigned GainW      = 16;
  localparam int unsigned ProdW      = CodeW + GainW;
  localparam int unsigned SumW       = 33;
  localparam int unsigned DivSteps   = SumW;
  localparam int unsigned StepW      = $clog2(DivSteps);
  localparam int unsigned MeanW      = 18;
  localparam int unsigned CountW     = 15;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned FoldShift  = 13;
  localparam int unsigned FoldW      = 18;

  localparam logic [CfgIdxW-1:0] CfgCodeOffset   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPositiveGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNegativeGain = 2'd2;

  localparam logic [GainW-1:0] GainReset      = 16'd16384;
  localparam logic [CodeW:0]   CodeFullScale  = 15'd16384;
  localparam logic [FoldShift:0] PosDivisor   = 14'd8191;
  localparam logic [SumW-1:0]  PosRoundBias   = SumW'(4095);
  localparam logic [ProdW:0]   NegRoundBias   = (ProdW + 1)'(2048);
  localparam int unsigned      NegShift       = 12;
  localparam logic [SumW-1:0]  MeanPosMax     = SumW'(131071);
  localparam logic [SumW-1:0]  MeanNegMag     = SumW'(131072);

  typedef struct packed {
    logic [CodeW-1:0] raw_code;
    logic             last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [MeanW-1:0] mean_value;
    logic [CountW-1:0]       sample_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CVT,
    S_FOLD,
    S_FIX,
    S_DIV,
    S_ACC,
    S_MSETUP,
    S_OUT
  } state_e;

endpackage

>>> sv/adc_calibrate_and_average_core.sv
// Per sample: a negative code passes IDLE, MUL and CVT, and a positive code also
// FOLD, FIX and ACC, where the divide by 8191 folds the 13-bit halves of the dividend.
// The last sample of a run adds the mean: setup in MSETUP, a 33-step restoring
// divider in DIV and a result load in OUT, which waits while an earlier result is held.
// Reset (rst_ni low, asynchronous) clears the run, the output valid and sets
// the registers to offset 0 and both gains to 1.0.
`include "adc_calibrate_and_average_core_macros.svh"

module adc_calibrate_and_average_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  aca_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output aca_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aca_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [aca_pkg::CfgDataW-1:0]        cfg_data_i
);

  aca_pkg::state_e state_q, state_d;

  logic [aca_pkg::CodeW-1:0]  offset_q;
  logic [aca_pkg::GainW-1:0]  pos_gain_q, neg_gain_q;

  logic [aca_pkg::CodeW-1:0]  operand_q;
  logic                       neg_code_q;
  logic                       last_q;
  logic [aca_pkg::ProdW-1:0]  prod_q;

  logic signed [aca_pkg::SumW-1:0] sum_q;
  logic [aca_pkg::SeenW-1:0]       seen_q;

  logic [aca_pkg::SumW-1:0]   quo_q;
  logic [aca_pkg::DvsrW-1:0]  rem_q;
  logic [aca_pkg::DvsrW-1:0]  dvsr_q;
  logic [aca_pkg::StepW-1:0]  step_q;
  logic                       neg_sum_q;
  logic [aca_pkg::FoldW-1:0]  fold_q;

  logic                       out_valid_q;
  aca_pkg::out_item_t         out_data_q;

  logic                       in_fire, cfg_fire, room, div_last, out_load;
  logic [aca_pkg::CodeW-1:0]  code_w;
  logic [aca_pkg::CodeW:0]    neg_mag_w;
  logic [aca_pkg::DvsrW:0]    trial;
  logic                       trial_ge;
  logic [aca_pkg::DvsrW-1:0]  rem_nxt;
  logic [aca_pkg::SumW-1:0]   quo_nxt;
  logic [aca_pkg::ProdW:0]    neg_round;
  logic [aca_pkg::SumW-1:0]   sum_mag;
  logic [aca_pkg::MeanW-1:0]  mean_w;
  logic [aca_pkg::FoldW-1:0]  fold_w;
  logic [aca_pkg::FoldShift:0] fold_low;
  logic                       fold_carry;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign room     = seen_q < aca_pkg::SeenW'(aca_pkg::MaxSamples);
  assign div_last = step_q == aca_pkg::StepW'(aca_pkg::DivSteps - 1);
  assign out_load = (state_q == aca_pkg::S_OUT) && (!out_valid_q || out_ready_i);

  assign code_w    = in_data_i.raw_code + offset_q;
  assign neg_mag_w = aca_pkg::CodeFullScale - {1'b0, code_w};

  // One restoring-division step: shift the next dividend bit into the remainder.
  assign trial    = {rem_q, quo_q[aca_pkg::SumW-1]};
  assign trial_ge = trial >= {1'b0, dvsr_q};
  assign rem_nxt  = trial_ge ? aca_pkg::DvsrW'(trial - {1'b0, dvsr_q})
                             : trial[aca_pkg::DvsrW-1:0];
  assign quo_nxt  = {quo_q[aca_pkg::SumW-2:0], trial_ge};

  // With x = hi * 8192 + lo we have x = hi * 8191 + (hi + lo), so the quotient
  // by 8191 is hi plus the small quotient of hi + lo, found by folding once more.
  assign fold_w     = aca_pkg::FoldW'(quo_q[aca_pkg::SumW-1:aca_pkg::FoldShift])
                    + aca_pkg::FoldW'(quo_q[aca_pkg::FoldShift-1:0]);
  assign fold_low   = {1'b0, fold_q[aca_pkg::FoldShift-1:0]}
                    + (aca_pkg::FoldShift + 1)'(fold_q[aca_pkg::FoldW-1:aca_pkg::FoldShift]);
  assign fold_carry = fold_low >= aca_pkg::PosDivisor;

  assign neg_round = {1'b0, prod_q} + aca_pkg::NegRoundBias;
  assign sum_mag   = sum_q[aca_pkg::SumW-1] ? aca_pkg::SumW'(-sum_q) : sum_q;

  always_comb begin
    if (neg_sum_q) begin
      mean_w = (quo_q > aca_pkg::MeanNegMag) ? aca_pkg::MeanW'(aca_pkg::MeanNegMag)
                                              : aca_pkg::MeanW'(-quo_q);
    end else begin
      mean_w = (quo_q > aca_pkg::MeanPosMax) ? aca_pkg::MeanW'(aca_pkg::MeanPosMax)
                                              : quo_q[aca_pkg::MeanW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      aca_pkg::S_IDLE: begin
        if (in_fire) begin
          if (room) state_d = aca_pkg::S_MUL;
          else if (in_data_i.last_sample) state_d = aca_pkg::S_MSETUP;
        end
      end
      aca_pkg::S_MUL: state_d = aca_pkg::S_CVT;
      aca_pkg::S_CVT: begin
        if (!neg_code_q) state_d = aca_pkg::S_FOLD;
        else if (last_q) state_d = aca_pkg::S_MSETUP;
        else state_d = aca_pkg::S_IDLE;
      end
      aca_pkg::S_FOLD: state_d = aca_pkg::S_FIX;
      aca_pkg::S_FIX: state_d = aca_pkg::S_ACC;
      aca_pkg::S_DIV: begin
        if (div_last) state_d = aca_pkg::S_OUT;
      end
      aca_pkg::S_ACC: state_d = last_q ? aca_pkg::S_MSETUP : aca_pkg::S_IDLE;
      aca_pkg::S_MSETUP: state_d = aca_pkg::S_DIV;
      aca_pkg::S_OUT: begin
        if (out_load) state_d = aca_pkg::S_IDLE;
      end
      default: state_d = aca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready_o = 1'b1;
    case (state_q)
      aca_pkg::S_IDLE: in_ready_o = 1'b1;
      default:         in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aca_pkg::S_IDLE;
      offset_q    <= '0;
      pos_gain_q  <= aca_pkg::GainReset;
      neg_gain_q  <= aca_pkg::GainReset;
      sum_q       <= '0;
      seen_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          aca_pkg::CfgCodeOffset:   offset_q   <= cfg_data_i[aca_pkg::CodeW-1:0];
          aca_pkg::CfgPositiveGain: pos_gain_q <= cfg_data_i;
          aca_pkg::CfgNegativeGain: neg_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        aca_pkg::S_CVT: begin
          if (neg_code_q) begin
            sum_q  <= sum_q - $signed(aca_pkg::SumW'(neg_round[aca_pkg::ProdW:aca_pkg::NegShift]));
            seen_q <= seen_q + 1'b1;
          end
        end
        aca_pkg::S_DIV:  step_q <= step_q + 1'b1;
        aca_pkg::S_ACC: begin
          sum_q  <= sum_q + $signed(quo_q);
          seen_q <= seen_q + 1'b1;
        end
        aca_pkg::S_MSETUP: begin
          step_q <= '0;
        end
        aca_pkg::S_OUT: begin
          if (out_load) begin
            sum_q  <= '0;
            seen_q <= '0;
          end
        end
        default: ;
      endcase
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      aca_pkg::S_IDLE: begin
        if (in_fire) begin
          neg_code_q <= code_w[aca_pkg::CodeW-1];
          operand_q  <= code_w[aca_pkg::CodeW-1] ? neg_mag_w[aca_pkg::CodeW-1:0] : code_w;
          last_q     <= in_data_i.last_sample;
        end
      end
      aca_pkg::S_MUL: prod_q <= (neg_code_q ? neg_gain_q : pos_gain_q) * operand_q;
      aca_pkg::S_CVT: begin
        quo_q <= aca_pkg::SumW'({prod_q, 1'b0}) + aca_pkg::PosRoundBias;
      end
      aca_pkg::S_FOLD: begin
        fold_q <= fold_w;
        quo_q  <= quo_q >> aca_pkg::FoldShift;
      end
      aca_pkg::S_FIX: begin
        quo_q <= quo_q + aca_pkg::SumW'(fold_q[aca_pkg::FoldW-1:aca_pkg::FoldShift])
               + aca_pkg::SumW'(fold_carry);
      end
      aca_pkg::S_DIV: begin
        quo_q <= quo_nxt;
        rem_q <= rem_nxt;
      end
      aca_pkg::S_MSETUP: begin
        // The run always counts at least one sample, so the count is nonzero.
        neg_sum_q <= sum_q[aca_pkg::SumW-1];
        quo_q     <= aca_pkg::SumW'({sum_mag, 1'b0}) + aca_pkg::SumW'(seen_q);
        rem_q     <= '0;
        dvsr_q    <= {seen_q, 1'b0};
      end
      aca_pkg::S_OUT: begin
        if (out_load) begin
          out_data_q.mean_value   <= mean_w;
          out_data_q.sample_count <= aca_pkg::CountW'(seen_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ACA_ASSERT_SAME(a_seen_bound, clk_i, rst_ni, 1'b1, seen_q <= aca_pkg::SeenW'(aca_pkg::MaxSamples))
  `ACA_ASSERT_SAME(a_step_bound, clk_i, rst_ni, state_q == aca_pkg::S_DIV, step_q < aca_pkg::StepW'(aca_pkg::DivSteps))
  `ACA_ASSERT_NEXT(a_run_cleared, clk_i, rst_ni, out_load, sum_q == '0 && seen_q == '0 && out_valid_q)

endmodule

>>> test/testbench.sv
module testbench;
  import aca_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam longint MeanTop = 131071;
  localparam longint MeanBottom = -131072;
  localparam int SettleCycles = 120;

  // Expected results of the calibrate and average datapath.
  class mean_scoreboard;
    logic [CodeW-1:0] code_offset;
    logic [GainW-1:0] positive_gain;
    logic [GainW-1:0] negative_gain;
    longint run_sum;
    int unsigned run_count;
    out_item_t mean_expected_q[$];
    int unsigned n_errors;
    int unsigned n_samples;
    int unsigned n_results;
    int unsigned n_writes;

    function new();
      code_offset = '0;
      positive_gain = GainReset;
      negative_gain = GainReset;
      run_sum = 0;
      run_count = 0;
      n_errors = 0;
      n_samples = 0;
      n_results = 0;
      n_writes = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      n_writes++;
      case (idx)
        CfgCodeOffset:   code_offset = data[CodeW-1:0];
        CfgPositiveGain: positive_gain = data;
        CfgNegativeGain: negative_gain = data;
        default: ;
      endcase
    endfunction

    function longint calibrate_code(logic [CodeW-1:0] raw);
      logic [CodeW-1:0] c;
      longint mag;
      c = raw + code_offset;
      if (c[CodeW-1]) begin
        mag = 16384 - longint'(c);
        return -((longint'(negative_gain) * mag + 2048) >>> 12);
      end
      return (2 * longint'(positive_gain) * longint'(c) + 4095) / 8191;
    endfunction

    function void note_sample(in_item_t s);
      longint mag;
      longint q;
      longint mean;
      bit neg;
      out_item_t exp_item;
      n_samples++;
      if (run_count < MaxSamples) begin
        run_sum += calibrate_code(s.raw_code);
        run_count++;
      end
      if (!s.last_sample) return;
      neg = run_sum < 0;
      mag = neg ? -run_sum : run_sum;
      q = (2 * mag + run_count) / (2 * longint'(run_count));
      if (neg) mean = (q > -MeanBottom) ? MeanBottom : -q;
      else mean = (q > MeanTop) ? MeanTop : q;
      exp_item.mean_value = mean[MeanW-1:0];
      exp_item.sample_count = run_count[CountW-1:0];
      mean_expected_q.push_back(exp_item);
      run_sum = 0;
      run_count = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      n_errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (mean_expected_q.size() == 0) begin
        report($sformatf("unexpected result mean %0d count %0d",
                         got.mean_value, got.sample_count));
        return;
      end
      want = mean_expected_q.pop_front();
      n_results++;
      if (got.mean_value !== want.mean_value)
        report($sformatf("result %0d: mean %0d, expected %0d",
                         n_results, got.mean_value, want.mean_value));
      if (got.sample_count !== want.sample_count)
        report($sformatf("result %0d: count %0d, expected %0d",
                         n_results, got.sample_count, want.sample_count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_item_t in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  mean_scoreboard sb = new();
  bit idle_on = 1'b1;
  int rx_hold = 0;

  adc_calibrate_and_average_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      sb.check_result(out_data_o);
      rx_hold = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(logic [CodeW-1:0] raw, logic last);
    int gap;
    in_item_t item;
    item.raw_code = raw;
    item.last_sample = last;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(item);
  endtask

  // Lower valid, let every pending result out, then let the last samples of
  // an open run clear the datapath before touching the registers.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.mean_expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_reg_value();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return GainReset;
      3: return 16'd16383;
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [CodeW-1:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 14'h0000;
      1: return 14'h1fff;
      2: return 14'h2000;
      3: return 14'h3fff;
      default: return CodeW'($urandom);
    endcase
  endfunction

  initial begin
    int run_len;
    int sent;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values first, then code wrap and the gain extremes.
    send_sample(14'h1fff, 1'b0);
    send_sample(14'h2000, 1'b0);
    send_sample(14'h3fff, 1'b0);
    send_sample(14'h0000, 1'b1);
    send_sample(14'h1fff, 1'b1);
    send_sample(14'h2000, 1'b1);
    drain();
    write_cfg(CfgCodeOffset, 16'h3fff);
    write_cfg(CfgPositiveGain, 16'hffff);
    write_cfg(CfgNegativeGain, 16'hffff);
    write_cfg(CfgUnused, 16'ha5a5);
    send_sample(14'h0000, 1'b0);
    send_sample(14'h2000, 1'b0);
    send_sample(14'h2001, 1'b0);
    send_sample(14'h3fff, 1'b1);
    send_sample(14'h0001, 1'b1);
    drain();
    write_cfg(CfgCodeOffset, 16'h0001);
    write_cfg(CfgPositiveGain, 16'h0000);
    write_cfg(CfgNegativeGain, 16'h0000);
    send_sample(14'h3fff, 1'b0);
    send_sample(14'h1fff, 1'b0);
    send_sample(14'h1234, 1'b1);
    drain();
    write_cfg(CfgCodeOffset, 16'hffff);
    write_cfg(CfgPositiveGain, GainReset);
    write_cfg(CfgNegativeGain, GainReset);
    send_sample(14'h0002, 1'b0);
    send_sample(14'h3ffe, 1'b1);
    send_sample(14'h0001, 1'b0);
    send_sample(14'h0002, 1'b1);

    // Random phases; some leave a run open across the register writes.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_cfg(CfgCodeOffset, pick_reg_value());
      write_cfg(CfgPositiveGain, pick_reg_value());
      write_cfg(CfgNegativeGain, pick_reg_value());
      sent = 0;
      while (sent < 128) begin
        idle_on = $urandom_range(0, 3) != 0;
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (int k = 0; k < run_len; k++) begin
          send_sample(pick_code(), (k == run_len - 1) && (sent + k < 123 || phase[0]));
        end
        sent += run_len;
      end
    end
    idle_on = 1'b1;

    drain();
    $display("Checked %0d averaged results from %0d samples across %0d register writes.",
             sb.n_results, sb.n_samples, sb.n_writes);
    $display("Covered offset wrap, gain extremes, stalls on both sides and open runs.");
    if (sb.n_errors == 0 && sb.mean_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/aca_pkg.sv
sv/adc_calibrate_and_average_core.sv
test/testbench.sv
